// ----- sv/pbpe_pkg.sv -----
`timescale 1ns / 1ps
package pbpe_pkg;

  localparam int BYTE_W  = 8;
  localparam int COL_W   = 12;
  localparam int ROW_W   = 12;
  localparam int COLOR_W = 24;
  localparam int RP_W    = 13;
  localparam int RB_W    = 13;
  localparam int CNT_W   = 4;
  localparam int NUM_PAL = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Pixels per byte in one-bit and two-bit modes
  localparam logic [CNT_W-1:0] PIX_PER_BYTE_1BPP = 4'd8;
  localparam logic [CNT_W-1:0] PIX_PER_BYTE_2BPP = 4'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PIXELS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_0  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_1  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_2  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_3  = 3'd7;

  // Bits of the mode register
  localparam int MODE_TRANS_BIT = 0;
  localparam int MODE_2BPP_BIT  = 1;

  typedef struct packed {
    logic [1:0]                      mode;
    logic [2:0]                      bit_offset;
    logic [RP_W-1:0]                 row_pixels;
    logic [RB_W-1:0]                 row_bytes;
    logic [NUM_PAL-1:0][COLOR_W-1:0] palette;
  } cfg_t;

  // One byte's worth of work handed from the row tracker to the emitter
  typedef struct packed {
    logic [BYTE_W-1:0] pix;
    logic [CNT_W-1:0]  count;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic              two_bit;
    logic              trans;
  } job_t;

endpackage

// ----- sv/pbpe_in_if.sv -----
`timescale 1ns / 1ps
interface pbpe_in_if import pbpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

// ----- sv/pbpe_out_if.sv -----
`timescale 1ns / 1ps
interface pbpe_out_if import pbpe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   column;
  logic [ROW_W-1:0]   row;
  logic [COLOR_W-1:0] color;
  logic               draw;
  logic               last;

  modport source (output valid, output column, output row, output color, output draw,
                  output last, input ready);
  modport sink (input valid, input column, input row, input color, input draw,
                input last, output ready);
endinterface

// ----- sv/pbpe_cfg_if.sv -----
`timescale 1ns / 1ps
interface pbpe_cfg_if import pbpe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/pbpe_cfg.sv -----
`timescale 1ns / 1ps
module pbpe_cfg import pbpe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_MODE:       cfg_nxt.mode       = wr_data[1:0];
        REG_BIT_OFFSET: cfg_nxt.bit_offset = wr_data[2:0];
        REG_ROW_PIXELS: cfg_nxt.row_pixels = wr_data[RP_W-1:0];
        REG_ROW_BYTES:  cfg_nxt.row_bytes  = wr_data[RB_W-1:0];
        REG_PALETTE_0:  cfg_nxt.palette[0] = wr_data[COLOR_W-1:0];
        REG_PALETTE_1:  cfg_nxt.palette[1] = wr_data[COLOR_W-1:0];
        REG_PALETTE_2:  cfg_nxt.palette[2] = wr_data[COLOR_W-1:0];
        REG_PALETTE_3:  cfg_nxt.palette[3] = wr_data[COLOR_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{mode: 2'd0, bit_offset: 3'd0, row_pixels: RP_W'(1),
                 row_bytes: RB_W'(1), palette: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/pbpe_row.sv -----
`timescale 1ns / 1ps
module pbpe_row import pbpe_pkg::*; #(
  parameter int MAX_ROW = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [BYTE_W-1:0] source_byte,
  input  cfg_t              cfg,
  output job_t              job,
  output logic              job_valid
);

  localparam int PIX_W = $clog2(MAX_ROW + 8);
  localparam int CW    = (PIX_W > RP_W) ? PIX_W : RP_W;

  logic [RB_W-1:0]  byte_in_row_r, byte_in_row_nxt;
  logic [PIX_W-1:0] pixel_in_row_r, pixel_in_row_nxt;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;

  logic [CW-1:0]     rp_ext, limit, pix_ext, left, pix_after;
  logic              two_bit, first, active, row_end;
  logic [CNT_W-1:0]  avail, n;
  logic [RB_W:0]     byte_sum;
  logic [PIX_W-1:0]  pix_sum;

  always_comb begin
    two_bit = cfg.mode[MODE_2BPP_BIT];
    first   = (byte_in_row_r == '0);
    rp_ext  = CW'(cfg.row_pixels);
    // Clamp the row length to 1..MAX_ROW
    if (rp_ext == '0) begin
      limit = CW'(1);
    end else if (rp_ext > CW'(MAX_ROW)) begin
      limit = CW'(MAX_ROW);
    end else begin
      limit = rp_ext;
    end
    pix_ext = CW'(pixel_in_row_r);
    active  = (pix_ext < limit);
    left    = limit - pix_ext;

    if (first) begin
      avail = two_bit ? PIX_PER_BYTE_2BPP - CNT_W'(cfg.bit_offset[2:1])
                      : PIX_PER_BYTE_1BPP - CNT_W'(cfg.bit_offset);
    end else begin
      avail = two_bit ? PIX_PER_BYTE_2BPP : PIX_PER_BYTE_1BPP;
    end

    if (!active) begin
      n = '0;
    end else if (left < CW'(avail)) begin
      n = left[CNT_W-1:0];
    end else begin
      n = avail;
    end

    pix_sum   = pixel_in_row_r + PIX_W'(n);
    pix_after = CW'(pix_sum);
    byte_sum  = {1'b0, byte_in_row_r} + (RB_W+1)'(1);
    row_end   = (pix_after >= limit) && (byte_sum >= {1'b0, cfg.row_bytes});

    byte_in_row_nxt  = byte_in_row_r;
    pixel_in_row_nxt = pixel_in_row_r;
    row_count_nxt    = row_count_r;
    if (take) begin
      if (row_end) begin
        byte_in_row_nxt  = '0;
        pixel_in_row_nxt = '0;
        row_count_nxt    = row_count_r + ROW_W'(1);
      end else begin
        byte_in_row_nxt  = byte_sum[RB_W-1:0];
        pixel_in_row_nxt = pix_sum;
      end
    end

    job.pix     = first ? (source_byte >> cfg.bit_offset) : source_byte;
    job.count   = n;
    job.column  = COL_W'(pixel_in_row_r);
    job.row     = row_count_r;
    job.two_bit = two_bit;
    job.trans   = cfg.mode[MODE_TRANS_BIT];
    job_valid   = (n != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_in_row_r  <= '0;
      pixel_in_row_r <= '0;
      row_count_r    <= '0;
    end else begin
      byte_in_row_r  <= byte_in_row_nxt;
      pixel_in_row_r <= pixel_in_row_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

endmodule

// ----- sv/pbpe_emit.sv -----
`timescale 1ns / 1ps
module pbpe_emit import pbpe_pkg::*; (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  job_t                            job,
  input  logic [NUM_PAL-1:0][COLOR_W-1:0] palette,
  output logic                            can_take,
  pbpe_out_if.source                      out_bus
);

  logic               busy_r, busy_nxt;
  job_t               job_r, job_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]   out_column_r, out_column_nxt;
  logic [ROW_W-1:0]   out_row_r, out_row_nxt;
  logic [COLOR_W-1:0] out_color_r, out_color_nxt;
  logic               out_draw_r, out_draw_nxt;
  logic               out_last_r, out_last_nxt;

  logic       adv, last_pix, draw;
  logic [1:0] idx;

  always_comb begin
    adv      = busy_r && (!out_valid_r || out_bus.ready);
    last_pix = (job_r.count == CNT_W'(1));
    can_take = !busy_r || (adv && last_pix);

    idx  = job_r.two_bit ? job_r.pix[1:0] : {1'b0, job_r.pix[0]};
    draw = !(job_r.trans && (idx == 2'd0));

    busy_nxt = busy_r;
    job_nxt  = job_r;
    if (adv) begin
      job_nxt.pix    = job_r.two_bit ? (job_r.pix >> 2) : (job_r.pix >> 1);
      job_nxt.count  = job_r.count - CNT_W'(1);
      job_nxt.column = job_r.column + COL_W'(1);
      if (last_pix) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      job_nxt  = job;
    end

    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_column_nxt = out_column_r;
    out_row_nxt    = out_row_r;
    out_color_nxt  = out_color_r;
    out_draw_nxt   = out_draw_r;
    out_last_nxt   = out_last_r;
    if (adv) begin
      out_valid_nxt  = 1'b1;
      out_column_nxt = job_r.column;
      out_row_nxt    = job_r.row;
      out_color_nxt  = draw ? palette[idx] : '0;
      out_draw_nxt   = draw;
      out_last_nxt   = last_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r        <= job_nxt;
    out_column_r <= out_column_nxt;
    out_row_r    <= out_row_nxt;
    out_color_r  <= out_color_nxt;
    out_draw_r   <= out_draw_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_bus.valid  = out_valid_r;
  assign out_bus.column = out_column_r;
  assign out_bus.row    = out_row_r;
  assign out_bus.color  = out_color_r;
  assign out_bus.draw   = out_draw_r;
  assign out_bus.last   = out_last_r;

endmodule

// ----- sv/packed_bitmap_palette_expander.sv -----
`timescale 1ns / 1ps
// Expands packed 1- or 2-bit-per-pixel bitmap bytes into palette colors, one
// pixel per cycle on out_bus while out_bus is ready, least significant bits
// first. A byte gives up to eight pixels (1 bpp) or four (2 bpp), and it holds
// the pixel emitter until its last pixel is out; its first pixel passes through
// the job register and then the output register to out_bus, and the next byte is
// taken in the cycle its last pixel moves into the output register, while padding
// bytes that give no pixel are taken without loading the emitter. A stalled
// result holds the emitter, so in_bus.ready follows out_bus.ready in the cycle of
// a byte's last pixel. Row position is tracked internally; row_pixels is clamped
// to 1..MAX_ROW, and row_bytes below the row's need acts as that need. Write the
// configuration only while the block is idle; cfg_bus is always ready.
module packed_bitmap_palette_expander import pbpe_pkg::*; #(
  parameter int MAX_ROW = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  pbpe_in_if.sink    in_bus,
  pbpe_out_if.source out_bus,
  pbpe_cfg_if.sink   cfg_bus
);

  cfg_t cfg;
  job_t job;
  logic job_valid;
  logic can_take;
  logic take;

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = can_take;
  assign take          = in_bus.valid && can_take;

  pbpe_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_bus.valid),
    .wr_index (cfg_bus.index),
    .wr_data  (cfg_bus.data),
    .cfg      (cfg)
  );

  pbpe_row #(
    .MAX_ROW (MAX_ROW)
  ) u_row (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .source_byte (in_bus.source_byte),
    .cfg         (cfg),
    .job         (job),
    .job_valid   (job_valid)
  );

  pbpe_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take && job_valid),
    .job      (job),
    .palette  (cfg.palette),
    .can_take (can_take),
    .out_bus  (out_bus)
  );

endmodule

// ----- sv/pbpe_chk.sv -----
`timescale 1ns / 1ps
module pbpe_chk import pbpe_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COL_W-1:0]   out_column,
  input logic [ROW_W-1:0]   out_row,
  input logic [COLOR_W-1:0] out_color,
  input logic               out_draw,
  input logic               out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_column) && $stable(out_row) && $stable(out_color) &&
      $stable(out_draw) && $stable(out_last))
    else $error("result payload changed while stalled");

  a_skip_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_draw |-> (out_color == '0))
    else $error("transparent pixel carries a color");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind packed_bitmap_palette_expander pbpe_chk u_pbpe_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_column (out_bus.column),
  .out_row    (out_bus.row),
  .out_color  (out_bus.color),
  .out_draw   (out_bus.draw),
  .out_last   (out_bus.last)
);

// ----- dv/palette_pixel_checker.sv -----
`timescale 1ns / 1ps
module palette_pixel_checker import pbpe_pkg::*; #(
  parameter int MAX_ROW = 4096
) (
  input  logic clk,
  input  logic rst_n,
  pbpe_in_if   in_mon,
  pbpe_out_if  out_mon,
  pbpe_cfg_if  cfg_mon,
  output int   errors,
  output int   pending
);

  localparam int SHOW_LIMIT = 50;

  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic [COLOR_W-1:0] color;
    logic               draw;
    logic               last;
  } pixel_t;

  pixel_t           expected_pixels[$];
  pixel_t           seen;
  pixel_t           wanted;
  cfg_t             regs;
  int unsigned      byte_in_row;
  int unsigned      pixel_in_row;
  logic [ROW_W-1:0] row_count;
  int               mismatches;

  function automatic void report_field(input string field, input logic [31:0] want_val,
                                       input logic [31:0] got_val);
    mismatches++;
    if (mismatches <= SHOW_LIMIT)
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field, want_val, got_val);
  endfunction

  // Split one source byte into palette pixels and queue them.
  function automatic void expand_byte(input logic [BYTE_W-1:0] src);
    int unsigned       row_limit;
    int unsigned       avail;
    int unsigned       left;
    int unsigned       count;
    logic [BYTE_W-1:0] bits;
    logic              two_bit;
    logic              trans;
    logic [1:0]        idx;
    pixel_t            px;
    row_limit = regs.row_pixels;
    if (row_limit == 0) row_limit = 1;
    if (row_limit > MAX_ROW) row_limit = MAX_ROW;
    two_bit = regs.mode[MODE_2BPP_BIT];
    trans = regs.mode[MODE_TRANS_BIT];
    bits = src;
    count = 0;
    if (pixel_in_row < row_limit) begin
      left = row_limit - pixel_in_row;
      if (byte_in_row == 0) begin
        bits = src >> regs.bit_offset;
        avail = two_bit ? PIX_PER_BYTE_2BPP - (regs.bit_offset >> 1)
                        : PIX_PER_BYTE_1BPP - regs.bit_offset;
      end else begin
        avail = two_bit ? PIX_PER_BYTE_2BPP : PIX_PER_BYTE_1BPP;
      end
      count = (avail < left) ? avail : left;
      for (int k = 0; k < count; k++) begin
        idx = two_bit ? bits[1:0] : {1'b0, bits[0]};
        bits = two_bit ? (bits >> 2) : (bits >> 1);
        px.column = COL_W'(pixel_in_row + k);
        px.row = row_count;
        px.draw = !(trans && idx == 2'd0);
        px.color = px.draw ? regs.palette[idx] : '0;
        px.last = (k + 1 == count);
        expected_pixels.push_back(px);
      end
      pixel_in_row += count;
    end
    byte_in_row++;
    // Close the row once its pixels are out and enough bytes have gone by.
    if (pixel_in_row >= row_limit && byte_in_row >= regs.row_bytes) begin
      byte_in_row = 0;
      pixel_in_row = 0;
      row_count = row_count + 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.mode = '0;
      regs.bit_offset = '0;
      regs.row_pixels = RP_W'(1);
      regs.row_bytes = RB_W'(1);
      regs.palette = '0;
      byte_in_row = 0;
      pixel_in_row = 0;
      row_count = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_MODE:       regs.mode = cfg_mon.data[1:0];
          REG_BIT_OFFSET: regs.bit_offset = cfg_mon.data[2:0];
          REG_ROW_PIXELS: regs.row_pixels = cfg_mon.data[RP_W-1:0];
          REG_ROW_BYTES:  regs.row_bytes = cfg_mon.data[RB_W-1:0];
          REG_PALETTE_0:  regs.palette[0] = cfg_mon.data[COLOR_W-1:0];
          REG_PALETTE_1:  regs.palette[1] = cfg_mon.data[COLOR_W-1:0];
          REG_PALETTE_2:  regs.palette[2] = cfg_mon.data[COLOR_W-1:0];
          REG_PALETTE_3:  regs.palette[3] = cfg_mon.data[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) expand_byte(in_mon.source_byte);
      if (out_mon.valid && out_mon.ready) begin
        seen.column = out_mon.column;
        seen.row = out_mon.row;
        seen.color = out_mon.color;
        seen.draw = out_mon.draw;
        seen.last = out_mon.last;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("%0t ns: unexpected pixel, expected none, actual column %0d row %0d color 0x%06h",
                     $time, seen.column, seen.row, seen.color);
        end else begin
          wanted = expected_pixels.pop_front();
          if (seen.column !== wanted.column) report_field("column", wanted.column, seen.column);
          if (seen.row !== wanted.row) report_field("row", wanted.row, seen.row);
          if (seen.color !== wanted.color) report_field("color", wanted.color, seen.color);
          if (seen.draw !== wanted.draw) report_field("draw", wanted.draw, seen.draw);
          if (seen.last !== wanted.last) report_field("last", wanted.last, seen.last);
        end
      end
    end
    pending <= expected_pixels.size();
    errors <= mismatches;
  end

endmodule

// ----- dv/tb_packed_bitmap_palette_expander.sv -----
`timescale 1ns / 1ps
module tb_packed_bitmap_palette_expander;
  import pbpe_pkg::*;

  localparam int MAX_ROW      = 4096;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;
  // Random rows; the directed cases add about twenty more bytes
  localparam int PIXEL_BYTES  = 140;

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   cycle_count;
  int   errors;
  int   pending;

  pbpe_in_if  in_bus();
  pbpe_out_if out_bus();
  pbpe_cfg_if cfg_bus();

  packed_bitmap_palette_expander #(.MAX_ROW(MAX_ROW)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  palette_pixel_checker #(.MAX_ROW(MAX_ROW)) u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_bus),
    .out_mon (out_bus),
    .cfg_mon (cfg_bus),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Keep cfg valid high between back-to-back writes; the caller drops it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic configure(input int mode, input int offset, input int rp, input int rb,
                           input logic [COLOR_W-1:0] c0, input logic [COLOR_W-1:0] c1,
                           input logic [COLOR_W-1:0] c2, input logic [COLOR_W-1:0] c3);
    write_reg(REG_MODE, CFG_DATA_W'(mode));
    write_reg(REG_BIT_OFFSET, CFG_DATA_W'(offset));
    write_reg(REG_ROW_PIXELS, CFG_DATA_W'(rp));
    write_reg(REG_ROW_BYTES, CFG_DATA_W'(rb));
    write_reg(REG_PALETTE_0, c0);
    write_reg(REG_PALETTE_1, c1);
    write_reg(REG_PALETTE_2, c2);
    write_reg(REG_PALETTE_3, c3);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] value);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.source_byte <= value;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Drain every queued pixel, then give padding bytes time to retire.
  task automatic settle();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int fmt_mode;
    int fmt_off;
    int fmt_rp;
    int fmt_rb;
    int first_pix;
    int per_byte;
    int need;
    int rows;
    int row_len;
    int extra;
    int counted;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.source_byte = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_MODE;
    cfg_bus.data = '0;
    out_bus.ready = 1'b0;
    tx_idle_pct = 34;
    rx_idle_pct <= 69;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One-bit opaque, full bytes, palette extremes
    configure(0, 0, 8, 1, 24'h000000, 24'hFFFFFF, 24'h123456, 24'hABCDEF);
    send_byte(8'h00);
    send_byte(8'hFF);
    settle();

    // One-bit transparent with an offset and a padding byte per row
    configure(1, 3, 13, 3, 24'hFFFFFF, 24'h00FF00, 24'h0000FF, 24'hFF0000);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h77);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h81);
    settle();

    // Two-bit opaque, odd offset, row_bytes below the row's need
    configure(2, 5, 6, 1, 24'h111111, 24'h222222, 24'h333333, 24'h444444);
    send_byte(8'hE4);
    send_byte(8'h1B);
    settle();

    // Two-bit transparent, largest offset leaves one half-read pixel pair
    configure(3, 7, 9, 2, 24'hC0FFEE, 24'h00FFFF, 24'hFF00FF, 24'hFFFFFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hE4);
    send_byte(8'h80);
    send_byte(8'h33);
    send_byte(8'hCC);
    settle();

    // Zero row_pixels acts as a single pixel
    configure(0, 0, 0, 1, 24'h0F0F0F, 24'hF0F0F0, 24'h000000, 24'h000000);
    send_byte(8'h01);
    send_byte(8'hFE);
    settle();

    // Oversized row, then shrink it below what was already emitted
    configure(0, 2, 8191, 4096, 24'h000001, 24'h800000, 24'h000000, 24'h000000);
    send_byte(8'h3C);
    send_byte(8'hC3);
    settle();
    configure(0, 2, 4, 1, 24'h000001, 24'h800000, 24'h000000, 24'h000000);
    send_byte(8'h99);
    send_byte(8'h5A);
    settle();

    counted = 0;
    while (counted < PIXEL_BYTES) begin
      if (counted < PIXEL_BYTES / 3) begin
        tx_idle_pct = 34;
        rx_idle_pct <= 69;
      end else if (counted < 2 * PIXEL_BYTES / 3) begin
        tx_idle_pct = 69;
        rx_idle_pct <= 34;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      fmt_mode = $urandom_range(3, 0);
      fmt_off = $urandom_range(7, 0);
      fmt_rp = ($urandom_range(7, 0) == 0) ? $urandom_range(120, 41) : $urandom_range(40, 1);
      per_byte = fmt_mode[MODE_2BPP_BIT] ? 4 : 8;
      first_pix = fmt_mode[MODE_2BPP_BIT] ? 4 - fmt_off / 2 : 8 - fmt_off;
      need = (fmt_rp <= first_pix) ? 1 : 1 + (fmt_rp - first_pix + per_byte - 1) / per_byte;
      fmt_rb = $urandom_range(need + 3, 1);
      configure(fmt_mode, fmt_off, fmt_rp, fmt_rb, COLOR_W'($urandom), COLOR_W'($urandom),
                COLOR_W'($urandom), COLOR_W'($urandom));
      rows = $urandom_range(3, 1);
      row_len = (fmt_rb > need) ? fmt_rb : need;
      repeat (rows * row_len) send_byte(BYTE_W'($urandom));
      counted += rows * row_len;
      // Leave a broken row behind now and then
      if ($urandom_range(5, 0) == 0) begin
        extra = $urandom_range(3, 1);
        repeat (extra) send_byte(BYTE_W'($urandom));
        counted += extra;
      end
      settle();
    end

    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
